// ----- hw/rtl/ppt_pkg.sv -----
package ppt_pkg;

   localparam int CoordWidth   = 32;
   localparam int AngleWidth   = 16;
   localparam int CordicStages = 16;

   // angles are widened to a full-turn word before the cordic
   localparam int TurnWidth   = 32;
   localparam int CordicWidth = TurnWidth + 1;
   localparam int TrigWidth   = CordicWidth + 1;
   localparam int OpWidth     = CoordWidth + 1;
   localparam int ProdWidth   = OpWidth + TrigWidth;
   localparam int SumWidth    = ProdWidth + 1;
   localparam int FracBits    = 30;
   localparam int ScaledWidth = SumWidth - FracBits;
   localparam int ResWidth    = ScaledWidth + 1;

   // 0.6072529350 in q2.30
   localparam int CordicGain = 652032874;

   localparam logic CmdRelative = 1'b0;
   localparam logic CmdCompose  = 1'b1;

   typedef struct packed {
      logic signed [CordicWidth-1:0] x;
      logic signed [CordicWidth-1:0] y;
      logic signed [CordicWidth-1:0] z;
   } cordic_type;

   typedef struct packed {
      logic                         command;
      logic                         flip;
      logic signed [OpWidth-1:0]    op_a;
      logic signed [OpWidth-1:0]    op_b;
      logic signed [CoordWidth-1:0] base_x;
      logic signed [CoordWidth-1:0] base_y;
      logic [AngleWidth-1:0]        heading;
   } side_type;

   // arctan(2^-i) as a fraction of one turn, 2^32 = full turn
   function automatic logic [TurnWidth-1:0] atan_turn(input int unsigned idx);
      logic [31:0] val;
      case (idx)
         0:       val = 32'h2000_0000;
         1:       val = 32'h12E4_051E;
         2:       val = 32'h09FB_385B;
         3:       val = 32'h0511_11D4;
         4:       val = 32'h028B_0D43;
         5:       val = 32'h0145_D7E1;
         6:       val = 32'h00A2_F61E;
         7:       val = 32'h0051_7C55;
         8:       val = 32'h0028_BE53;
         9:       val = 32'h0014_5F2F;
         10:      val = 32'h000A_2F98;
         11:      val = 32'h0005_17CC;
         12:      val = 32'h0002_8BE6;
         13:      val = 32'h0001_45F3;
         14:      val = 32'h0000_A2FA;
         15:      val = 32'h0000_517D;
         16:      val = 32'h0000_28BE;
         17:      val = 32'h0000_145F;
         18:      val = 32'h0000_0A30;
         19:      val = 32'h0000_0518;
         20:      val = 32'h0000_028C;
         21:      val = 32'h0000_0146;
         22:      val = 32'h0000_00A3;
         23:      val = 32'h0000_0051;
         default: val = 32'h0000_0000;
      endcase
      return TurnWidth'(val);
   endfunction

endpackage

// ----- hw/rtl/ppt_front.sv -----
module ppt_front (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 in_valid,
   input  logic                                 command,
   input  logic signed [ppt_pkg::CoordWidth-1:0] base_x,
   input  logic signed [ppt_pkg::CoordWidth-1:0] base_y,
   input  logic signed [ppt_pkg::AngleWidth-1:0] base_heading,
   input  logic signed [ppt_pkg::CoordWidth-1:0] other_x,
   input  logic signed [ppt_pkg::CoordWidth-1:0] other_y,
   input  logic signed [ppt_pkg::AngleWidth-1:0] other_heading,
   output logic                                 out_valid,
   output ppt_pkg::cordic_type                  out_vec,
   output ppt_pkg::side_type                    out_side
);

   localparam int TW = ppt_pkg::TurnWidth;

   logic                    valid_ff;
   ppt_pkg::cordic_type     vec_ff, vec_in;
   ppt_pkg::side_type       side_ff, side_in;
   logic [TW-1:0]           turn;
   logic [TW-1:0]           probe;
   logic [TW-1:0]           folded;
   logic                    flip;

   always_comb begin
      turn   = {base_heading, (TW - ppt_pkg::AngleWidth)'(0)};
      // angles outside [-pi/2, pi/2) are moved by half a turn
      probe  = turn + (TW'(1) << (TW - 2));
      flip   = probe[TW-1];
      folded = flip ? {~turn[TW-1], turn[TW-2:0]} : turn;

      vec_in.x = ppt_pkg::CordicWidth'(ppt_pkg::CordicGain);
      vec_in.y = '0;
      vec_in.z = ppt_pkg::CordicWidth'($signed(folded));

      side_in.command = command;
      side_in.flip    = flip;
      side_in.base_x  = base_x;
      side_in.base_y  = base_y;
      if (command == ppt_pkg::CmdCompose) begin
         side_in.op_a    = ppt_pkg::OpWidth'(other_x);
         side_in.op_b    = ppt_pkg::OpWidth'(other_y);
         side_in.heading = base_heading + other_heading;
      end else begin
         side_in.op_a    = ppt_pkg::OpWidth'(other_x) - ppt_pkg::OpWidth'(base_x);
         side_in.op_b    = ppt_pkg::OpWidth'(other_y) - ppt_pkg::OpWidth'(base_y);
         side_in.heading = other_heading - base_heading;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      vec_ff  <= vec_in;
      side_ff <= side_in;
   end

   assign out_valid = valid_ff;
   assign out_vec   = vec_ff;
   assign out_side  = side_ff;

endmodule

// ----- hw/rtl/ppt_cordic.sv -----
module ppt_cordic (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   input  ppt_pkg::cordic_type in_vec,
   input  ppt_pkg::side_type   in_side,
   output logic                out_valid,
   output ppt_pkg::cordic_type out_vec,
   output ppt_pkg::side_type   out_side
);

   localparam int NS = ppt_pkg::CordicStages;
   localparam int CW = ppt_pkg::CordicWidth;

   logic                valid_ff [NS];
   ppt_pkg::cordic_type vec_ff   [NS];
   ppt_pkg::side_type   side_ff  [NS];

   for (genvar i = 0; i < NS; i++) begin : g_stage
      logic                valid_src;
      ppt_pkg::cordic_type vec_src;
      ppt_pkg::side_type   side_src;
      ppt_pkg::cordic_type vec_in;
      logic signed [CW-1:0] xs;
      logic signed [CW-1:0] ys;
      logic signed [CW-1:0] angle;

      if (i == 0) begin : g_first
         assign valid_src = in_valid;
         assign vec_src   = in_vec;
         assign side_src  = in_side;
      end else begin : g_next
         assign valid_src = valid_ff[i-1];
         assign vec_src   = vec_ff[i-1];
         assign side_src  = side_ff[i-1];
      end

      always_comb begin
         xs    = $signed(vec_src.x) >>> i;
         ys    = $signed(vec_src.y) >>> i;
         angle = CW'(ppt_pkg::atan_turn(i));
         // zero residual rotates the positive way
         if (!vec_src.z[CW-1]) begin
            vec_in.x = vec_src.x - ys;
            vec_in.y = vec_src.y + xs;
            vec_in.z = vec_src.z - angle;
         end else begin
            vec_in.x = vec_src.x + ys;
            vec_in.y = vec_src.y - xs;
            vec_in.z = vec_src.z + angle;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[i] <= 1'b0;
         end else begin
            valid_ff[i] <= valid_src;
         end
      end

      always_ff @(posedge clock) begin
         vec_ff[i]  <= vec_in;
         side_ff[i] <= side_src;
      end
   end

   assign out_valid = valid_ff[NS-1];
   assign out_vec   = vec_ff[NS-1];
   assign out_side  = side_ff[NS-1];

endmodule

// ----- hw/rtl/ppt_rotate.sv -----
module ppt_rotate (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 in_valid,
   input  ppt_pkg::cordic_type                  in_vec,
   input  ppt_pkg::side_type                    in_side,
   output logic                                 out_valid,
   output logic signed [ppt_pkg::CoordWidth-1:0] out_x,
   output logic signed [ppt_pkg::CoordWidth-1:0] out_y,
   output logic [ppt_pkg::AngleWidth-1:0]        out_heading,
   output logic                                 saturated
);

   localparam int TRW = ppt_pkg::TrigWidth;
   localparam int PW  = ppt_pkg::ProdWidth;
   localparam int SW  = ppt_pkg::SumWidth;
   localparam int RW  = ppt_pkg::ResWidth;
   localparam int CO  = ppt_pkg::CoordWidth;

   // stage f: fold correction and sign of the sine terms
   logic                   f_valid_ff;
   ppt_pkg::side_type      f_side_ff;
   logic signed [TRW-1:0]  f_cos_ff, f_cos_in;
   logic signed [TRW-1:0]  f_sin_x_ff, f_sin_x_in;
   logic signed [TRW-1:0]  f_sin_y_ff, f_sin_y_in;
   logic signed [TRW-1:0]  x_ext, y_ext;
   logic                   neg_x;

   always_comb begin
      x_ext = TRW'($signed(in_vec.x));
      y_ext = TRW'($signed(in_vec.y));
      // relative: rx = a*c + b*s, ry = b*c - a*s; compose flips the sine terms
      neg_x      = in_side.flip ^ (in_side.command == ppt_pkg::CmdCompose);
      f_cos_in   = in_side.flip ? -x_ext : x_ext;
      f_sin_x_in = neg_x ? -y_ext : y_ext;
      f_sin_y_in = neg_x ? y_ext : -y_ext;
   end

   // stage m: four products
   logic                   m_valid_ff;
   ppt_pkg::side_type      m_side_ff;
   logic signed [PW-1:0]   m_ac_ff, m_bs_ff, m_bc_ff, m_as_ff;

   // stage s: dot products, rounded and scaled
   logic                   s_valid_ff;
   ppt_pkg::side_type      s_side_ff;
   logic signed [ppt_pkg::ScaledWidth-1:0] s_x_ff, s_x_in;
   logic signed [ppt_pkg::ScaledWidth-1:0] s_y_ff, s_y_in;
   logic signed [SW-1:0]   sum_x, sum_y;
   logic signed [SW-1:0]   half;

   always_comb begin
      half   = SW'(1) <<< (ppt_pkg::FracBits - 1);
      sum_x  = SW'(m_ac_ff) + SW'(m_bs_ff) + half;
      sum_y  = SW'(m_bc_ff) + SW'(m_as_ff) + half;
      s_x_in = sum_x[SW-1:ppt_pkg::FracBits];
      s_y_in = sum_y[SW-1:ppt_pkg::FracBits];
   end

   // stage c: base offset and clamp
   logic                   c_valid_ff;
   logic signed [CO-1:0]   c_x_ff, c_x_in;
   logic signed [CO-1:0]   c_y_ff, c_y_in;
   logic [ppt_pkg::AngleWidth-1:0] c_heading_ff;
   logic                   c_sat_ff, c_sat_in;
   logic signed [RW-1:0]   res_x, res_y;
   logic [RW-CO:0]         top_x, top_y;
   logic                   sat_x, sat_y;
   logic signed [CO-1:0]   max_coord, min_coord;

   always_comb begin
      max_coord = {1'b0, {(CO-1){1'b1}}};
      min_coord = {1'b1, {(CO-1){1'b0}}};
      if (s_side_ff.command == ppt_pkg::CmdCompose) begin
         res_x = RW'(s_x_ff) + RW'(s_side_ff.base_x);
         res_y = RW'(s_y_ff) + RW'(s_side_ff.base_y);
      end else begin
         res_x = RW'(s_x_ff);
         res_y = RW'(s_y_ff);
      end
      // out of range when the coordinate sign bit and the bits above it disagree
      top_x  = res_x[RW-1:CO-1];
      top_y  = res_y[RW-1:CO-1];
      sat_x  = !((&top_x) || !(|top_x));
      sat_y  = !((&top_y) || !(|top_y));
      c_x_in = sat_x ? (res_x[RW-1] ? min_coord : max_coord) : res_x[CO-1:0];
      c_y_in = sat_y ? (res_y[RW-1] ? min_coord : max_coord) : res_y[CO-1:0];
      c_sat_in = sat_x | sat_y;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f_valid_ff <= 1'b0;
         m_valid_ff <= 1'b0;
         s_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
      end else begin
         f_valid_ff <= in_valid;
         m_valid_ff <= f_valid_ff;
         s_valid_ff <= m_valid_ff;
         c_valid_ff <= s_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      f_side_ff    <= in_side;
      f_cos_ff     <= f_cos_in;
      f_sin_x_ff   <= f_sin_x_in;
      f_sin_y_ff   <= f_sin_y_in;

      m_side_ff    <= f_side_ff;
      m_ac_ff      <= PW'($signed(f_side_ff.op_a)) * PW'(f_cos_ff);
      m_bs_ff      <= PW'($signed(f_side_ff.op_b)) * PW'(f_sin_x_ff);
      m_bc_ff      <= PW'($signed(f_side_ff.op_b)) * PW'(f_cos_ff);
      m_as_ff      <= PW'($signed(f_side_ff.op_a)) * PW'(f_sin_y_ff);

      s_side_ff    <= m_side_ff;
      s_x_ff       <= s_x_in;
      s_y_ff       <= s_y_in;

      c_x_ff       <= c_x_in;
      c_y_ff       <= c_y_in;
      c_heading_ff <= s_side_ff.heading;
      c_sat_ff     <= c_sat_in;
   end

   assign out_valid   = c_valid_ff;
   assign out_x       = c_x_ff;
   assign out_y       = c_y_ff;
   assign out_heading = c_heading_ff;
   assign saturated   = c_sat_ff;

endmodule

// ----- hw/rtl/planar_pose_transform.sv -----
// channel  | ports                                   | handshake
// ---------+-----------------------------------------+----------------------------
// request  | req_command, req_base_*, req_other_*    | beat taken when start && !busy
// response | rsp_out_x, rsp_out_y, rsp_out_heading,  | beat shown for one cycle
//          | rsp_saturated                           | with rsp_valid high
//
// one beat per cycle while busy is low; each request passes, in order, through
// one operand stage, one cordic iteration per stage (16), then fold,
// multiply, round and clamp stages.
// busy is high only during reset and the cycle after it.
// the response side cannot stall, so the pipeline never holds.
module planar_pose_transform (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic                                 req_command,
   input  logic signed [ppt_pkg::CoordWidth-1:0] req_base_x,
   input  logic signed [ppt_pkg::CoordWidth-1:0] req_base_y,
   input  logic signed [ppt_pkg::AngleWidth-1:0] req_base_heading,
   input  logic signed [ppt_pkg::CoordWidth-1:0] req_other_x,
   input  logic signed [ppt_pkg::CoordWidth-1:0] req_other_y,
   input  logic signed [ppt_pkg::AngleWidth-1:0] req_other_heading,
   output logic                                 rsp_valid,
   output logic signed [ppt_pkg::CoordWidth-1:0] rsp_out_x,
   output logic signed [ppt_pkg::CoordWidth-1:0] rsp_out_y,
   output logic signed [ppt_pkg::AngleWidth-1:0] rsp_out_heading,
   output logic                                 rsp_saturated
);

   logic                busy_ff;
   logic                accept;
   logic                front_valid;
   ppt_pkg::cordic_type front_vec;
   ppt_pkg::side_type   front_side;
   logic                cordic_valid;
   ppt_pkg::cordic_type cordic_vec;
   ppt_pkg::side_type   cordic_side;
   logic [ppt_pkg::AngleWidth-1:0] heading;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b1;
      end else begin
         busy_ff <= 1'b0;
      end
   end

   assign busy   = busy_ff;
   assign accept = start & ~busy_ff;

   ppt_front u_front (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (accept),
      .command       (req_command),
      .base_x        (req_base_x),
      .base_y        (req_base_y),
      .base_heading  (req_base_heading),
      .other_x       (req_other_x),
      .other_y       (req_other_y),
      .other_heading (req_other_heading),
      .out_valid     (front_valid),
      .out_vec       (front_vec),
      .out_side      (front_side)
   );

   ppt_cordic u_cordic (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (front_valid),
      .in_vec    (front_vec),
      .in_side   (front_side),
      .out_valid (cordic_valid),
      .out_vec   (cordic_vec),
      .out_side  (cordic_side)
   );

   ppt_rotate u_rotate (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (cordic_valid),
      .in_vec      (cordic_vec),
      .in_side     (cordic_side),
      .out_valid   (rsp_valid),
      .out_x       (rsp_out_x),
      .out_y       (rsp_out_y),
      .out_heading (heading),
      .saturated   (rsp_saturated)
   );

   assign rsp_out_heading = $signed(heading);

endmodule

// ----- sim/planar_pose_transform_checker.sv -----
module planar_pose_transform_checker (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   input  logic                                  busy,
   input  logic                                  req_command,
   input  logic signed [ppt_pkg::CoordWidth-1:0] req_base_x,
   input  logic signed [ppt_pkg::CoordWidth-1:0] req_base_y,
   input  logic signed [ppt_pkg::AngleWidth-1:0] req_base_heading,
   input  logic signed [ppt_pkg::CoordWidth-1:0] req_other_x,
   input  logic signed [ppt_pkg::CoordWidth-1:0] req_other_y,
   input  logic signed [ppt_pkg::AngleWidth-1:0] req_other_heading,
   input  logic                                  rsp_valid,
   input  logic signed [ppt_pkg::CoordWidth-1:0] rsp_out_x,
   input  logic signed [ppt_pkg::CoordWidth-1:0] rsp_out_y,
   input  logic signed [ppt_pkg::AngleWidth-1:0] rsp_out_heading,
   input  logic                                  rsp_saturated,
   output int                                    mismatch_count,
   output int                                    poses_in_flight
);

   typedef struct packed {
      logic signed [ppt_pkg::CoordWidth-1:0] x;
      logic signed [ppt_pkg::CoordWidth-1:0] y;
      logic signed [ppt_pkg::AngleWidth-1:0] heading;
      logic                                  saturated;
   } pose_result_type;

   // arctan(2^-i) in turns, 2^32 = one full turn
   longint arctan_turn [0:23] = '{
      64'h2000_0000, 64'h12E4_051E, 64'h09FB_385B, 64'h0511_11D4,
      64'h028B_0D43, 64'h0145_D7E1, 64'h00A2_F61E, 64'h0051_7C55,
      64'h0028_BE53, 64'h0014_5F2F, 64'h000A_2F98, 64'h0005_17CC,
      64'h0002_8BE6, 64'h0001_45F3, 64'h0000_A2FA, 64'h0000_517D,
      64'h0000_28BE, 64'h0000_145F, 64'h0000_0A30, 64'h0000_0518,
      64'h0000_028C, 64'h0000_0146, 64'h0000_00A3, 64'h0000_0051
   };

   pose_result_type expected_poses[$];
   pose_result_type predicted;
   pose_result_type oldest;
   int              beats_seen;

   initial begin
      mismatch_count  = 0;
      poses_in_flight = 0;
      beats_seen      = 0;
   end

   // (a*p + b*q) / 2^30, rounded half up, computed without overflow
   function automatic longint rounded_dot(input longint a, input longint p,
                                          input longint b, input longint q);
      logic signed [95:0] wa, wp, wb, wq, acc;
      wa  = 96'(a);
      wp  = 96'(p);
      wb  = 96'(b);
      wq  = 96'(q);
      acc = wa * wp + wb * wq + (96'sd1 <<< (ppt_pkg::FracBits - 1));
      return longint'(acc >>> ppt_pkg::FracBits);
   endfunction

   function automatic logic signed [ppt_pkg::CoordWidth-1:0] clamp_coord(input longint v,
                                                                         inout logic sat);
      longint hi, lo;
      hi = (longint'(1) <<< (ppt_pkg::CoordWidth - 1)) - 1;
      lo = -hi - 1;
      if (v > hi) begin
         sat = 1'b1;
         return ppt_pkg::CoordWidth'(hi);
      end
      if (v < lo) begin
         sat = 1'b1;
         return ppt_pkg::CoordWidth'(lo);
      end
      return ppt_pkg::CoordWidth'(v);
   endfunction

   function automatic pose_result_type transform_pose(
      input logic                                  cmd,
      input logic signed [ppt_pkg::CoordWidth-1:0] bx,
      input logic signed [ppt_pkg::CoordWidth-1:0] by,
      input logic [ppt_pkg::AngleWidth-1:0]        bh,
      input logic signed [ppt_pkg::CoordWidth-1:0] ox,
      input logic signed [ppt_pkg::CoordWidth-1:0] oy,
      input logic [ppt_pkg::AngleWidth-1:0]        oh
   );
      logic [ppt_pkg::TurnWidth-1:0]        turn;
      logic [ppt_pkg::TurnWidth-1:0]        probe;
      logic signed [ppt_pkg::TurnWidth-1:0] residual;
      logic                                 flip;
      logic                                 sat;
      longint                               cx, cy, cz, xs, ys, c, s, dx, dy, rx, ry;
      pose_result_type                      res;
      turn  = {bh, {(ppt_pkg::TurnWidth-ppt_pkg::AngleWidth){1'b0}}};
      probe = turn + 32'h4000_0000;
      flip  = probe[ppt_pkg::TurnWidth-1];
      // outside [-pi/2, pi/2): rotate by pi and negate afterwards
      if (flip) begin
         turn = turn + 32'h8000_0000;
      end
      residual = turn;
      cz = longint'(residual);
      cx = longint'(ppt_pkg::CordicGain);
      cy = 0;
      for (int i = 0; i < ppt_pkg::CordicStages && i < 24; i++) begin
         xs = cx >>> i;
         ys = cy >>> i;
         if (cz >= 0) begin
            cx = cx - ys;
            cy = cy + xs;
            cz = cz - arctan_turn[i];
         end else begin
            cx = cx + ys;
            cy = cy - xs;
            cz = cz + arctan_turn[i];
         end
      end
      c = flip ? -cx : cx;
      s = flip ? -cy : cy;
      if (cmd == ppt_pkg::CmdRelative) begin
         dx = longint'(ox) - longint'(bx);
         dy = longint'(oy) - longint'(by);
         rx = rounded_dot(dx, c, dy, s);
         ry = rounded_dot(dx, -s, dy, c);
         res.heading = oh - bh;
      end else begin
         rx = longint'(bx) + rounded_dot(longint'(ox), c, longint'(oy), -s);
         ry = longint'(by) + rounded_dot(longint'(ox), s, longint'(oy), c);
         res.heading = bh + oh;
      end
      sat = 1'b0;
      res.x = clamp_coord(rx, sat);
      res.y = clamp_coord(ry, sat);
      res.saturated = sat;
      return res;
   endfunction

   task automatic report_mismatch(input string what);
      $display("%0t mismatch on result beat %0d: %s", $time, beats_seen, what);
      mismatch_count++;
   endtask

   task automatic check_field(input string name, input longint want, input longint got);
      if (want != got) begin
         report_mismatch($sformatf("%s expected %0d got %0d", name, want, got));
      end
   endtask

   always @(posedge clock) begin
      if (!reset && start && !busy) begin
         predicted = transform_pose(req_command, req_base_x, req_base_y, req_base_heading,
                                    req_other_x, req_other_y, req_other_heading);
         expected_poses.push_back(predicted);
      end
      if (!reset && rsp_valid) begin
         if (expected_poses.size() == 0) begin
            report_mismatch("result beat with no request outstanding");
         end else begin
            oldest = expected_poses.pop_front();
            check_field("out_x", longint'(oldest.x), longint'(rsp_out_x));
            check_field("out_y", longint'(oldest.y), longint'(rsp_out_y));
            check_field("out_heading", longint'(oldest.heading),
                        longint'(rsp_out_heading));
            check_field("saturated", longint'(oldest.saturated),
                        longint'(rsp_saturated));
         end
         beats_seen++;
      end
      poses_in_flight <= expected_poses.size();
   end

endmodule

// ----- sim/planar_pose_transform_tb.sv -----
module planar_pose_transform_tb;

   localparam int          RandomPairs = 1400;
   localparam int unsigned CycleLimit  = 400000;
   localparam int          SettleBeats = 40;

   localparam logic signed [ppt_pkg::CoordWidth-1:0] CoordMax =
      {1'b0, {(ppt_pkg::CoordWidth-1){1'b1}}};
   localparam logic signed [ppt_pkg::CoordWidth-1:0] CoordMin =
      {1'b1, {(ppt_pkg::CoordWidth-1){1'b0}}};
   localparam logic signed [ppt_pkg::AngleWidth-1:0] HeadingPi =
      {1'b1, {(ppt_pkg::AngleWidth-1){1'b0}}};
   localparam logic signed [ppt_pkg::AngleWidth-1:0] HeadingMax =
      {1'b0, {(ppt_pkg::AngleWidth-1){1'b1}}};
   localparam logic signed [ppt_pkg::AngleWidth-1:0] HeadingQuarter =
      {2'b01, {(ppt_pkg::AngleWidth-2){1'b0}}};

   logic                                  clock = 1'b0;
   logic                                  reset;
   logic                                  start;
   logic                                  busy;
   logic                                  req_command;
   logic signed [ppt_pkg::CoordWidth-1:0] req_base_x;
   logic signed [ppt_pkg::CoordWidth-1:0] req_base_y;
   logic signed [ppt_pkg::AngleWidth-1:0] req_base_heading;
   logic signed [ppt_pkg::CoordWidth-1:0] req_other_x;
   logic signed [ppt_pkg::CoordWidth-1:0] req_other_y;
   logic signed [ppt_pkg::AngleWidth-1:0] req_other_heading;
   logic                                  rsp_valid;
   logic signed [ppt_pkg::CoordWidth-1:0] rsp_out_x;
   logic signed [ppt_pkg::CoordWidth-1:0] rsp_out_y;
   logic signed [ppt_pkg::AngleWidth-1:0] rsp_out_heading;
   logic                                  rsp_saturated;
   int                                    mismatch_count;
   int                                    poses_in_flight;
   int unsigned                           cycle_count = 0;
   bit                                    back_to_back;

   always #5 clock = ~clock;

   planar_pose_transform DUT (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_command       (req_command),
      .req_base_x        (req_base_x),
      .req_base_y        (req_base_y),
      .req_base_heading  (req_base_heading),
      .req_other_x       (req_other_x),
      .req_other_y       (req_other_y),
      .req_other_heading (req_other_heading),
      .rsp_valid         (rsp_valid),
      .rsp_out_x         (rsp_out_x),
      .rsp_out_y         (rsp_out_y),
      .rsp_out_heading   (rsp_out_heading),
      .rsp_saturated     (rsp_saturated)
   );

   planar_pose_transform_checker pose_check (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_command       (req_command),
      .req_base_x        (req_base_x),
      .req_base_y        (req_base_y),
      .req_base_heading  (req_base_heading),
      .req_other_x       (req_other_x),
      .req_other_y       (req_other_y),
      .req_other_heading (req_other_heading),
      .rsp_valid         (rsp_valid),
      .rsp_out_x         (rsp_out_x),
      .rsp_out_y         (rsp_out_y),
      .rsp_out_heading   (rsp_out_heading),
      .rsp_saturated     (rsp_saturated),
      .mismatch_count    (mismatch_count),
      .poses_in_flight   (poses_in_flight)
   );

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CycleLimit) begin
         $display("FAIL planar_pose_transform");
         $finish;
      end
   end

   // one request beat; returns at the edge that took it
   task automatic send_pair(input logic                                  cmd,
                            input logic signed [ppt_pkg::CoordWidth-1:0] bx,
                            input logic signed [ppt_pkg::CoordWidth-1:0] by,
                            input logic signed [ppt_pkg::AngleWidth-1:0] bh,
                            input logic signed [ppt_pkg::CoordWidth-1:0] ox,
                            input logic signed [ppt_pkg::CoordWidth-1:0] oy,
                            input logic signed [ppt_pkg::AngleWidth-1:0] oh);
      int unsigned gap;
      gap = back_to_back ? 0 : $urandom_range(0, 15);
      if (gap != 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start             <= 1'b1;
      req_command       <= cmd;
      req_base_x        <= bx;
      req_base_y        <= by;
      req_base_heading  <= bh;
      req_other_x       <= ox;
      req_other_y       <= oy;
      req_other_heading <= oh;
      do @(posedge clock); while (busy);
   endtask

   // the in-flight count is registered, so the task waits on the clock before it looks
   task automatic wait_for_drain();
      start <= 1'b0;
      do @(posedge clock); while (poses_in_flight != 0);
   endtask

   function automatic logic signed [ppt_pkg::CoordWidth-1:0] pick_coord();
      case ($urandom_range(0, 9))
         0, 1, 2, 3: return ppt_pkg::CoordWidth'($urandom);
         4, 5, 6, 7: return ppt_pkg::CoordWidth'(int'($urandom_range(0, 2097152)) - 1048576);
         8:          return ppt_pkg::CoordWidth'($signed($urandom) >>> 3);
         default: begin
            case ($urandom_range(0, 4))
               0:       return CoordMax;
               1:       return CoordMin;
               2:       return '0;
               3:       return '1;
               default: return ppt_pkg::CoordWidth'(1);
            endcase
         end
      endcase
   endfunction

   function automatic logic signed [ppt_pkg::AngleWidth-1:0] pick_heading();
      if ($urandom_range(0, 7) != 0) begin
         return ppt_pkg::AngleWidth'($urandom);
      end
      case ($urandom_range(0, 4))
         0:       return '0;
         1:       return HeadingQuarter;
         2:       return -HeadingQuarter;
         3:       return HeadingPi;
         default: return HeadingMax;
      endcase
   endfunction

   initial begin
      reset             <= 1'b1;
      start             <= 1'b0;
      req_command       <= ppt_pkg::CmdRelative;
      req_base_x        <= '0;
      req_base_y        <= '0;
      req_base_heading  <= '0;
      req_other_x       <= '0;
      req_other_y       <= '0;
      req_other_heading <= '0;
      back_to_back = 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      send_pair(ppt_pkg::CmdRelative, 0, 0, 0, 0, 0, 0);
      send_pair(ppt_pkg::CmdCompose, 0, 0, 0, 0, 0, 0);
      // fold boundary at plus and minus a quarter turn
      send_pair(ppt_pkg::CmdCompose, 0, 0, HeadingQuarter, 65536, 0, 0);
      send_pair(ppt_pkg::CmdCompose, 0, 0, -HeadingQuarter, 65536, 0, 0);
      send_pair(ppt_pkg::CmdCompose, 0, 0, HeadingPi, 65536, 131072, 0);
      send_pair(ppt_pkg::CmdCompose, 0, 0, HeadingMax, 65536, 131072, 0);
      send_pair(ppt_pkg::CmdRelative, 98304, -147456, 8192, -196608, 262144, -8192);
      // position clamps in both directions
      send_pair(ppt_pkg::CmdRelative, CoordMax, CoordMax, 0, CoordMin, CoordMin, 0);
      send_pair(ppt_pkg::CmdRelative, CoordMin, CoordMin, HeadingPi, CoordMax, CoordMax, 0);
      send_pair(ppt_pkg::CmdCompose, CoordMax, CoordMax, 0, CoordMax, CoordMax, 0);
      send_pair(ppt_pkg::CmdCompose, CoordMin, CoordMin, 0, CoordMin, CoordMin, 0);
      send_pair(ppt_pkg::CmdCompose, CoordMax, CoordMin, 0, -1, 1, 0);
      send_pair(ppt_pkg::CmdCompose, CoordMax, 0, 4096, 1048576, 0, 0);
      // heading sums and differences that wrap; those landing on pi read back as minus pi
      send_pair(ppt_pkg::CmdCompose, 0, 0, HeadingQuarter, 0, 0, HeadingQuarter);
      send_pair(ppt_pkg::CmdRelative, 0, 0, -HeadingQuarter, 0, 0, HeadingQuarter);
      send_pair(ppt_pkg::CmdRelative, 0, 0, HeadingMax, 0, 0, HeadingPi);
      send_pair(ppt_pkg::CmdCompose, 0, 0, HeadingPi, 0, 0, HeadingPi);
      send_pair(ppt_pkg::CmdRelative, CoordMin, CoordMin, 12345, CoordMin, CoordMin, -12345);
      send_pair(ppt_pkg::CmdCompose, 7, -9, 5461, 1, -1, 3);
      send_pair(ppt_pkg::CmdRelative, 32'sh5555_5555, 32'sh5555_5555, 16'sh5555,
                -1, 32'shAAAA_AAAA, 16'shAAAA);
      send_pair(ppt_pkg::CmdCompose, 32'shAAAA_AAAA, -1, 16'shAAAA,
                32'sh5555_5555, 32'sh5555_5555, 16'sh5555);
      send_pair(ppt_pkg::CmdCompose, -1, -1, -1, -1, -1, -1);
      wait_for_drain();

      for (int n = 0; n < RandomPairs; n++) begin
         if (n % 50 == 0) begin
            back_to_back = ($urandom_range(0, 3) == 0);
         end
         if (n % 350 == 349) begin
            wait_for_drain();
         end
         send_pair($urandom_range(0, 1) ? ppt_pkg::CmdCompose : ppt_pkg::CmdRelative,
                   pick_coord(), pick_coord(), pick_heading(),
                   pick_coord(), pick_coord(), pick_heading());
      end
      wait_for_drain();
      repeat (SettleBeats) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("PASS planar_pose_transform");
      end else begin
         $display("FAIL planar_pose_transform");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
hw/rtl/ppt_pkg.sv
hw/rtl/ppt_front.sv
hw/rtl/ppt_cordic.sv
hw/rtl/ppt_rotate.sv
hw/rtl/planar_pose_transform.sv
sim/planar_pose_transform_checker.sv
sim/planar_pose_transform_tb.sv
